// ===== sv/ist_pkg.sv =====
// Shared widths and types for the insertion sort block.
package ist_pkg;

   localparam int DATA_W       = 32;
   localparam int SHIFT_W      = 11;
   localparam int WRITE_W      = 12;
   localparam int MAX_ITEMS_DEF = 32;

   // Data one cell hands to its neighbors.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     valid;
      logic                     gt;
   } ist_link_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic insert;
      logic shift_down;
   } ist_cell_ctrl_type;

   // Command to the counter unit.
   typedef struct packed {
      logic load;
      logic clear;
   } ist_tally_ctrl_type;

endpackage

// ===== sv/ist_cell.sv =====
// One cell of the sorting chain: holds one element and its valid bit.
module ist_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  ist_pkg::ist_cell_ctrl_type       ctrl,
   input  logic signed [ist_pkg::DATA_W-1:0] new_value,
   input  ist_pkg::ist_link_type            prev_link,
   input  ist_pkg::ist_link_type            next_link,
   output ist_pkg::ist_link_type            link,
   output logic                             take
);
   import ist_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     valid_ff;
   logic                     valid_in;
   logic                     gt;

   // Only strictly greater elements move up, which keeps equal values in order.
   assign gt   = valid_ff && (value_ff > new_value);
   assign take = ctrl.insert && !prev_link.gt && (gt || (!valid_ff && prev_link.valid));

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift_down) begin
         value_in = next_link.value;
         valid_in = next_link.valid;
      end else if (ctrl.insert && prev_link.gt) begin
         value_in = prev_link.value;
         valid_in = 1'b1;
      end else if (take) begin
         value_in = new_value;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign link.value = value_ff;
   assign link.valid = valid_ff;
   assign link.gt    = gt;

endmodule

// ===== sv/ist_tally.sv =====
// Shift and write counters, updated from a registered copy of the insertion position.
module ist_tally #(
   parameter int MAX_ITEMS = ist_pkg::MAX_ITEMS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ist_pkg::ist_tally_ctrl_type        ctrl,
   input  logic [MAX_ITEMS-1:0]               take,
   input  logic [$clog2(MAX_ITEMS+1)-1:0]     fill,
   output logic [ist_pkg::SHIFT_W-1:0]        shift_total,
   output logic [ist_pkg::WRITE_W-1:0]        write_total
);
   import ist_pkg::*;

   localparam int FILL_W = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W  = $clog2(MAX_ITEMS);

   logic [MAX_ITEMS-1:0] take_ff;
   logic [FILL_W-1:0]    snap_ff;
   logic                 pend_ff;
   logic [SHIFT_W-1:0]   shift_ff;
   logic [SHIFT_W-1:0]   shift_in;
   logic [WRITE_W-1:0]   write_ff;
   logic [WRITE_W-1:0]   write_in;
   logic [IDX_W-1:0]     pos;
   logic [FILL_W-1:0]    moved;

   // One-hot insertion position to binary.
   always_comb begin
      pos = '0;
      for (int i = 0; i < MAX_ITEMS; i++) begin
         if (take_ff[i]) begin
            pos = pos | IDX_W'(i);
         end
      end
   end

   assign moved = snap_ff - FILL_W'(pos);

   always_comb begin
      shift_in = shift_ff;
      write_in = write_ff;
      if (ctrl.clear) begin
         shift_in = '0;
         write_in = '0;
      end else if (pend_ff) begin
         shift_in = shift_ff + SHIFT_W'(moved);
         write_in = write_ff + WRITE_W'(moved) + WRITE_W'(snap_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      take_ff <= take;
      snap_ff <= fill;
      if (reset) begin
         pend_ff  <= 1'b0;
         shift_ff <= '0;
         write_ff <= '0;
      end else begin
         pend_ff  <= ctrl.load;
         shift_ff <= shift_in;
         write_ff <= write_in;
      end
   end

   assign shift_total = shift_ff;
   assign write_total = write_ff;

endmodule

// ===== sv/insertion_sort_with_counters.sv =====
// Top level: stable insertion sort over a chain of cells, with shift and write counts.
// Loading: one beat per cycle; every cell compares and shifts at once, so an element
//   is placed in the cycle it is accepted.
// After the marked beat: a settle state for the counters, then one result per cycle
//   unless rsp_stall is high, smallest first, from cell 0 while the chain shifts down.
// Reset (synchronous, active high) empties the chain and clears counts and flag.
module insertion_sort_with_counters #(
   parameter int MAX_ITEMS = ist_pkg::MAX_ITEMS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [ist_pkg::DATA_W-1:0]  req_item_value,
   input  logic                               req_is_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [ist_pkg::DATA_W-1:0]  rsp_sorted_value,
   output logic                               rsp_final_item,
   output logic [ist_pkg::SHIFT_W-1:0]        rsp_shift_count,
   output logic [ist_pkg::WRITE_W-1:0]        rsp_write_count,
   output logic                               rsp_overflowed
);
   import ist_pkg::*;

   localparam int FILL_W = $clog2(MAX_ITEMS + 1);

   typedef enum logic [1:0] {LOAD, SETTLE, DRAIN} state_type;

   state_type           state_ff;
   state_type           state_in;
   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;
   logic                overflow_ff;
   logic                overflow_in;

   logic                in_beat;
   logic                full;
   logic                out_beat;
   logic                last_beat;

   ist_cell_ctrl_type   cell_ctrl;
   ist_tally_ctrl_type  tally_ctrl;
   ist_link_type        links [MAX_ITEMS];
   logic [MAX_ITEMS-1:0] take;
   logic [MAX_ITEMS-1:0] cell_valid;

   // Input handshake: take beats only while loading.
   assign req_stall = (state_ff != LOAD);
   assign in_beat   = req_valid && !req_stall;
   assign full      = (fill_ff == FILL_W'(MAX_ITEMS));

   // Output handshake: cell 0 always holds the smallest remaining element.
   assign out_beat  = (state_ff == DRAIN) && !rsp_stall;
   assign last_beat = out_beat && (fill_ff == FILL_W'(1));

   // Insert unless the chain is full; on a drained beat, shift every cell down.
   assign cell_ctrl.insert     = in_beat && !full;
   assign cell_ctrl.shift_down = out_beat;

   assign tally_ctrl.load  = cell_ctrl.insert;
   assign tally_ctrl.clear = last_beat;

   // The chain: each cell talks to its two neighbors only.
   generate
      for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
         ist_link_type prev_link;
         ist_link_type next_link;

         if (i == 0) begin : g_head
            // Head sees a valid, never-greater neighbor below it.
            assign prev_link.value = '0;
            assign prev_link.valid = 1'b1;
            assign prev_link.gt    = 1'b0;
         end else begin : g_body
            assign prev_link = links[i-1];
         end

         if (i == MAX_ITEMS - 1) begin : g_tail
            // Drain pulls an empty slot into the tail.
            assign next_link = '0;
         end else begin : g_inner
            assign next_link = links[i+1];
         end

         ist_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .new_value (req_item_value),
            .prev_link (prev_link),
            .next_link (next_link),
            .link      (links[i]),
            .take      (take[i])
         );

         assign cell_valid[i] = links[i].valid;
      end
   endgenerate

   ist_tally #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_tally (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (tally_ctrl),
      .take        (take),
      .fill        (fill_ff),
      .shift_total (rsp_shift_count),
      .write_total (rsp_write_count)
   );

   // Sequencer: load until the marked beat, settle the counters, then drain.
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      overflow_in = overflow_ff;
      case (state_ff)
         LOAD: begin
            if (in_beat) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               if (req_is_last) begin
                  state_in = SETTLE;
               end
            end
         end
         SETTLE: begin
            state_in = DRAIN;
         end
         DRAIN: begin
            if (out_beat) begin
               fill_in = fill_ff - FILL_W'(1);
            end
            if (last_beat) begin
               overflow_in = 1'b0;
               state_in    = LOAD;
            end
         end
         default: begin
            state_in = LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= LOAD;
         fill_ff     <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_valid        = (state_ff == DRAIN);
   assign rsp_sorted_value = links[0].value;
   assign rsp_final_item   = (fill_ff == FILL_W'(1));
   assign rsp_overflowed   = overflow_ff;

   // At most one cell takes the new element.
   a_take_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(take))
      else $error("more than one cell took the new element");

   // While draining the head cell holds a live element.
   a_drain_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DRAIN) |-> (cell_valid[0] && (fill_ff != '0)))
      else $error("drain with empty head cell");

   // The last result empties the chain and returns to loading.
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      last_beat |=> ((fill_ff == '0) && (state_ff == LOAD) && (cell_valid == '0)))
      else $error("chain not empty after final result");

   // An insertion marks exactly one more cell valid.
   a_fill_tracks: assert property (@(posedge clock) disable iff (reset)
      cell_ctrl.insert |=> ($countones(cell_valid) == $countones($past(cell_valid)) + 1))
      else $error("valid cells out of step with insertion");

endmodule
